// File: rtl/assert_macros.svh
// Shared assertion macros for the vertex remap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge unless the given condition is true.
`define VIR_ASSERT_DIS(lbl, clk, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (cond) prop) else $error(msg);

// Check a property on every rising edge outside of an active-low reset.
`define VIR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    `VIR_ASSERT_DIS(lbl, clk, !(rst_n), prop, msg)

`endif

// File: rtl/vir_pkg.sv
`default_nettype none

package vir_pkg;

    localparam int IDX_W       = 12;    // local index, base, returned index
    localparam int CNT_W       = 13;    // vertex count, dense counter
    localparam int ADDR_W      = 13;    // base plus local index
    localparam int SPAN_W      = 14;    // base plus vertex count
    localparam int POOL_SIZE_W = 13;
    localparam int ADDR_SPAN   = 2 ** ADDR_W;
    localparam int Q_DEPTH     = 2;

    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 13'd4096;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_BEYOND  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_REV
    } t_back_state;

    typedef struct packed {
        logic              new_primitive;
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_item;

endpackage

`default_nettype wire

// File: rtl/vir_req_if.sv
`default_nettype none

interface vir_req_if import vir_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             new_primitive;
    logic [IDX_W-1:0] local_index;
    logic [IDX_W-1:0] cluster_first_vertex;
    logic [CNT_W-1:0] cluster_vertex_count;

    modport source (
        output valid, new_primitive, local_index, cluster_first_vertex,
               cluster_vertex_count,
        input  ready
    );

    modport sink (
        input  valid, new_primitive, local_index, cluster_first_vertex,
               cluster_vertex_count,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/vir_rsp_if.sv
`default_nettype none

interface vir_rsp_if import vir_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] primitive_index;
    logic             fetch_vertex;
    logic [IDX_W-1:0] vertex_address;
    logic [1:0]       status;

    modport source (
        output valid, primitive_index, fetch_vertex, vertex_address, status,
        input  ready
    );

    modport sink (
        input  valid, primitive_index, fetch_vertex, vertex_address, status,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/vertex_index_remap.sv
`default_nettype none
// Channel   Dir  Handshake        Payload
// i_req     in   valid / ready    new_primitive, local_index, cluster_first_vertex,
//                                 cluster_vertex_count
// o_rsp     out  valid / ready    primitive_index, fetch_vertex, vertex_address, status
// i_cfg_*   in   write enable     vertex_pool_size
//
// In the back end each request passes through the queue pop with the address-map
// read, the reverse-map read, then compare, table update and result load.
// The front end classifies and queues a request in its accept cycle; the back
// end pops the next one only when idle and the result register is free or taken.
// After reset the address map is swept once, all min(POOL_VERTICES, 8192) rows,
// with i_req.ready low; configuration writes are taken throughout.
// A stalled o_rsp holds the result register; the 2-deep queue keeps taking
// requests until it fills, then drops i_req.ready.

module vertex_index_remap import vir_pkg::*; #(
    parameter int POOL_VERTICES = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [POOL_SIZE_W-1:0] i_cfg_wdata,
    vir_req_if.sink                     i_req,
    vir_rsp_if.source                   o_rsp
);

    localparam int ITEM_W = $bits(t_item);

    logic              clearing;
    logic              q_full;
    logic              q_push;
    t_item             push_item;
    logic              q_valid;
    logic [ITEM_W-1:0] q_data;
    t_item             q_item;
    logic              q_pop;

    // front: hold the pool size, range-check and classify each request
    vir_front #(.POOL_VERTICES(POOL_VERTICES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_hold      (clearing),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_item      (push_item)
    );

    // decouple: classified requests wait here while the back end is busy
    vir_queue #(.WIDTH(ITEM_W), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_full  (q_full)
    );

    assign q_item = q_data;

    // back: look up, assign dense indices, advance the counter, drive results
    vir_back #(.POOL_VERTICES(POOL_VERTICES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

// File: rtl/vir_ram.sv
`default_nettype none

module vir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/vir_queue.sv
`default_nettype none
`include "assert_macros.svh"

module vir_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic [CNT_QW-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_QW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_data  = r_mem[r_rd_ptr];

    `VIR_ASSERT_RST(a_no_overrun, i_clk, i_rst_n, i_push |-> !o_full, "queue pushed while full")
    `VIR_ASSERT_RST(a_no_underrun, i_clk, i_rst_n, i_pop |-> o_valid, "queue popped while empty")

endmodule

`default_nettype wire

// File: rtl/vir_front.sv
`default_nettype none
`include "assert_macros.svh"

module vir_front import vir_pkg::*; #(
    parameter int POOL_VERTICES = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [POOL_SIZE_W-1:0] i_cfg_wdata,
    vir_req_if.sink                     i_req,
    input  wire logic                   i_hold,
    input  wire logic                   i_q_full,
    output logic                        o_push,
    output t_item                       o_item
);

    localparam int PW    = $clog2(POOL_VERTICES + 1);
    localparam int CMP_W = (PW > SPAN_W) ? PW : SPAN_W;
    localparam logic [CMP_W-1:0] POOL_MAX = CMP_W'(POOL_VERTICES);

    logic [POOL_SIZE_W-1:0] r_pool_size;
    logic [CMP_W-1:0]       pool_ext;
    logic [CMP_W-1:0]       pool_eff;
    logic [CMP_W-1:0]       span_end;
    logic [ADDR_W-1:0]      addr;
    t_status                status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_SIZE_RST;
        end else if (i_cfg_we) begin
            r_pool_size <= i_cfg_wdata;
        end
    end

    always_comb begin
        pool_ext = CMP_W'(r_pool_size);
        pool_eff = (pool_ext > POOL_MAX) ? POOL_MAX : pool_ext;
        span_end = CMP_W'(i_req.cluster_first_vertex) + CMP_W'(i_req.cluster_vertex_count);
        addr     = ADDR_W'(i_req.cluster_first_vertex) + ADDR_W'(i_req.local_index);
        // cluster range first, then the index, then the pooled address itself
        if (span_end > pool_eff) begin
            status = ST_BEYOND;
        end else if (CNT_W'(i_req.local_index) >= i_req.cluster_vertex_count) begin
            status = ST_OUTSIDE;
        end else if (CMP_W'(addr) >= POOL_MAX) begin
            status = ST_BEYOND;
        end else begin
            status = ST_OK;
        end
    end

    assign i_req.ready          = !i_hold && !i_q_full;
    assign o_push               = i_req.valid && i_req.ready;
    assign o_item.new_primitive = i_req.new_primitive;
    assign o_item.addr          = addr;
    assign o_item.status        = status;

    `VIR_ASSERT_RST(a_ok_in_pool, i_clk, i_rst_n, (o_push && o_item.status == ST_OK) |-> (CMP_W'(o_item.addr) < POOL_MAX), "clean item beyond the pool")

endmodule

`default_nettype wire

// File: rtl/vir_back.sv
`default_nettype none
`include "assert_macros.svh"

module vir_back import vir_pkg::*; #(
    parameter int POOL_VERTICES = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_q_pop,
    output logic       o_clearing,
    vir_rsp_if.source  o_rsp
);

    localparam int TBL_DEPTH = (POOL_VERTICES < ADDR_SPAN) ? POOL_VERTICES : ADDR_SPAN;
    localparam int AW = $clog2(TBL_DEPTH);
    localparam logic [AW-1:0] LAST_ROW = AW'(TBL_DEPTH - 1);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [AW-1:0]    r_clr_addr;
    t_item            r_item;
    logic [CNT_W-1:0] r_map;
    logic [CNT_W-1:0] r_dense;
    logic [CNT_W-1:0] n_dense;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_fetch;
    logic [IDX_W-1:0] r_out_addr;
    t_status          r_out_status;

    logic             out_take;
    logic             start;
    logic             item_ok;
    logic             hit;
    logic             write_new;

    logic             map_we;
    logic [AW-1:0]    map_waddr;
    logic [CNT_W-1:0] map_wdata;
    logic [AW-1:0]    map_raddr;
    logic [CNT_W-1:0] map_rdata;
    logic             rev_we;
    logic [AW-1:0]    rev_raddr;
    logic [AW-1:0]    rev_rdata;

    // address -> dense index, and dense index -> address; an entry is live
    // only when both agree and the index is below the current counter
    vir_ram #(.WIDTH(CNT_W), .DEPTH(TBL_DEPTH)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    vir_ram #(.WIDTH(AW), .DEPTH(TBL_DEPTH)) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (rev_we),
        .i_waddr (r_dense[AW-1:0]),
        .i_wdata (r_item.addr[AW-1:0]),
        .i_raddr (rev_raddr),
        .o_rdata (rev_rdata)
    );

    assign out_take  = r_out_valid && o_rsp.ready;
    assign start     = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || out_take);
    assign item_ok   = (r_item.status == ST_OK);
    assign hit       = (r_map < r_dense) && (rev_rdata == r_item.addr[AW-1:0]);
    assign write_new = (r_state == S_REV) && item_ok && !hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_MAP;
                end
            end
            S_MAP:   n_state = S_REV;
            S_REV:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        map_we     = 1'b0;
        map_waddr  = r_item.addr[AW-1:0];
        map_wdata  = r_dense;
        map_raddr  = i_q_item.addr[AW-1:0];
        rev_we     = 1'b0;
        rev_raddr  = map_rdata[AW-1:0];
        n_dense    = r_dense;
        case (r_state)
            S_CLEAR: begin
                o_clearing = 1'b1;
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                map_wdata  = '0;
            end
            S_IDLE: begin
                o_q_pop = start;
                if (start && i_q_item.new_primitive) begin
                    n_dense = '0;
                end
            end
            S_MAP: begin
                rev_raddr = map_rdata[AW-1:0];
            end
            S_REV: begin
                if (write_new) begin
                    map_we  = 1'b1;
                    rev_we  = 1'b1;
                    n_dense = r_dense + CNT_W'(1);
                end
            end
            default: begin
                o_clearing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_dense     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_dense <= n_dense;
            if (r_state == S_REV) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_MAP) begin
            r_map <= map_rdata;
        end
        if (r_state == S_REV) begin
            r_out_addr   <= r_item.addr[IDX_W-1:0];
            r_out_status <= r_item.status;
            r_out_fetch  <= write_new;
            if (!item_ok) begin
                r_out_index <= '0;
            end else if (hit) begin
                r_out_index <= r_map[IDX_W-1:0];
            end else begin
                r_out_index <= r_dense[IDX_W-1:0];
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.primitive_index = r_out_index;
    assign o_rsp.fetch_vertex    = r_out_fetch;
    assign o_rsp.vertex_address  = r_out_addr;
    assign o_rsp.status          = r_out_status;

    `VIR_ASSERT_RST(a_out_free, i_clk, i_rst_n, (r_state == S_REV) |-> !r_out_valid,
                    "lookup finished with result register full")
    `VIR_ASSERT_RST(a_dense_step, i_clk, i_rst_n,
                    write_new |=> (r_dense == $past(r_dense) + CNT_W'(1)),
                    "dense counter missed a new vertex")
    `VIR_ASSERT_RST(a_clear_quiet, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !i_q_valid,
                    "request queued during the clearing pass")

endmodule

`default_nettype wire
